// ===== sv/four_lane_crc32c_hash_top_defines.svh =====
// Assertion macros shared by the hash block.
`ifndef FOUR_LANE_CRC32C_HASH_TOP_DEFINES_SVH
`define FOUR_LANE_CRC32C_HASH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FLCH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("flch assertion failed");
`define FLCH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("flch assertion failed");
`else
`define FLCH_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define FLCH_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/flch_pkg.sv =====
package flch_pkg;

	localparam int unsigned MAX_MESSAGE_BYTES = 65536;
	localparam int unsigned CFG_W = 17;
	localparam int unsigned LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int unsigned WIDE_W = CFG_W + LEN_W;
	localparam int unsigned BYTE_CNT_W = 4;
	localparam int unsigned WORD_BYTES = 8;
	localparam int unsigned BLOCK_BYTES = 32;
	localparam logic [CFG_W-1:0] MESSAGE_BYTES_RESET = CFG_W'(4096);

	localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;
	localparam logic [63:0] FMIX_K1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_K2 = 64'hc4ceb9fe1a85ec53;
	localparam int unsigned FMIX_SHIFT = 33;
	localparam int unsigned HALF_SHIFT = 32;

	typedef enum logic [2:0] {
		FM_NONE,
		FM_LOAD_Y,
		FM_LOAD_X,
		FM_MUL_LL,
		FM_MUL_HL,
		FM_MUL_LH,
		FM_XSHIFT
	} fm_op_t;

	typedef struct packed {
		logic       capture;
		logic       load_seed;
		logic       crc_step;
		logic [1:0] lane;
		fm_op_t     fm_op;
		logic       ksel;
		logic       push;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'b0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC32C_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

// ===== sv/flch_datapath.sv =====
module flch_datapath
	import flch_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [63:0] data_word,
	input  logic [63:0] seed,
	output dp_status_t  status,
	output logic [63:0] hash,
	output logic        hash_valid,
	input  logic        hash_ready
);

	logic [63:0] word_q;
	logic [31:0] lanes_q [4];
	logic [63:0] f_q;
	logic [63:0] pacc_q;
	logic [63:0] hash_q;
	logic        hash_valid_q;

	logic [63:0] y_val;
	logic [63:0] x_val;
	logic [63:0] k_val;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;

	always_comb begin
		y_val = {lanes_q[2], lanes_q[3]};
		x_val = {lanes_q[0], lanes_q[1]} ^ f_q;
		k_val = cmd.ksel ? FMIX_K2 : FMIX_K1;
		mul_a = (cmd.fm_op == FM_MUL_HL) ? f_q[63:32] : f_q[31:0];
		mul_b = (cmd.fm_op == FM_MUL_LH) ? k_val[63:32] : k_val[31:0];
		prod = 64'(mul_a) * 64'(mul_b);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			word_q <= data_word;
		end else if (cmd.crc_step) begin
			word_q <= word_q >> 8;
		end
		if (cmd.load_seed) begin
			lanes_q[0] <= seed[31:0];
			lanes_q[1] <= seed[63:32];
			lanes_q[2] <= ~seed[31:0];
			lanes_q[3] <= ~seed[63:32];
		end else if (cmd.crc_step) begin
			lanes_q[cmd.lane] <= crc_byte(lanes_q[cmd.lane], word_q[7:0]);
		end
		case (cmd.fm_op)
			FM_LOAD_Y: f_q <= y_val ^ (y_val >> FMIX_SHIFT);
			FM_LOAD_X: f_q <= x_val ^ (x_val >> FMIX_SHIFT);
			FM_MUL_LL: pacc_q <= prod;
			FM_MUL_HL, FM_MUL_LH: pacc_q[63:32] <= pacc_q[63:32] + prod[31:0];
			FM_XSHIFT: f_q <= pacc_q ^ (pacc_q >> FMIX_SHIFT);
			default: ;
		endcase
		if (cmd.push) begin
			hash_q <= f_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_valid_q <= 1'b0;
		end else if (cmd.push) begin
			hash_valid_q <= 1'b1;
		end else if (hash_ready) begin
			hash_valid_q <= 1'b0;
		end
	end

	assign hash = hash_q;
	assign hash_valid = hash_valid_q;
	assign status.out_busy = hash_valid_q & ~hash_ready;

endmodule

// ===== sv/flch_ctrl.sv =====
module flch_ctrl
	import flch_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             word_valid,
	output logic             word_ready,
	input  logic             cfg_valid,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             cfg_ready,
	input  dp_status_t       status,
	output dp_cmd_t          cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CRC,
		ST_LOAD_Y,
		ST_MUL_LL,
		ST_MUL_HL,
		ST_MUL_LH,
		ST_XSHIFT,
		ST_LOAD_X,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [CFG_W-1:0]      msg_bytes_q;
	logic [LEN_W-1:0]      pos_q;
	logic [BYTE_CNT_W-1:0] left_q;
	logic [1:0]            lane_q;
	logic                  last_q;
	logic                  ksel_q;
	logic                  second_q;

	logic                  accept;
	logic [LEN_W-1:0]      len_eff;
	logic [LEN_W-1:0]      block_end;
	logic [LEN_W-1:0]      rem;
	logic [BYTE_CNT_W-1:0] nbytes;
	logic [1:0]            lane;
	logic                  last;
	logic [LEN_W:0]        pos_plus;

	assign word_ready = (state_q == ST_IDLE);
	assign accept = word_valid & word_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (msg_bytes_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (WIDE_W'(msg_bytes_q) > WIDE_W'(MAX_MESSAGE_BYTES)) begin
			len_eff = LEN_W'(MAX_MESSAGE_BYTES);
		end else begin
			len_eff = LEN_W'(msg_bytes_q);
		end
		block_end = len_eff & ~LEN_W'(BLOCK_BYTES - 1);
		rem = len_eff - pos_q;
		pos_plus = (LEN_W + 1)'(pos_q) + (LEN_W + 1)'(WORD_BYTES);
		last = (pos_plus >= (LEN_W + 1)'(len_eff));
		lane = 2'(pos_q >> 3);
		if (pos_q < block_end) begin
			nbytes = BYTE_CNT_W'(WORD_BYTES);
		end else if (pos_q < len_eff) begin
			nbytes = (rem > LEN_W'(WORD_BYTES)) ? BYTE_CNT_W'(WORD_BYTES) : rem[BYTE_CNT_W-1:0];
			lane = 2'd0;
		end else begin
			nbytes = '0;
			lane = 2'd0;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.capture = accept;
		cmd.load_seed = accept && (pos_q == '0);
		cmd.lane = lane_q;
		cmd.ksel = ksel_q;
		cmd.fm_op = FM_NONE;
		case (state_q)
			ST_CRC: cmd.crc_step = 1'b1;
			ST_LOAD_Y: cmd.fm_op = FM_LOAD_Y;
			ST_LOAD_X: cmd.fm_op = FM_LOAD_X;
			ST_MUL_LL: cmd.fm_op = FM_MUL_LL;
			ST_MUL_HL: cmd.fm_op = FM_MUL_HL;
			ST_MUL_LH: cmd.fm_op = FM_MUL_LH;
			ST_XSHIFT: cmd.fm_op = FM_XSHIFT;
			ST_EMIT: cmd.push = ~status.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			msg_bytes_q <= MESSAGE_BYTES_RESET;
			pos_q <= '0;
			left_q <= '0;
			lane_q <= '0;
			last_q <= 1'b0;
			ksel_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				msg_bytes_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (word_valid) begin
						pos_q <= last ? '0 : pos_plus[LEN_W-1:0];
						left_q <= nbytes;
						lane_q <= lane;
						last_q <= last;
						ksel_q <= 1'b0;
						second_q <= 1'b0;
						if (nbytes != '0) begin
							state_q <= ST_CRC;
						end else if (last) begin
							state_q <= ST_LOAD_Y;
						end
					end
				end
				ST_CRC: begin
					left_q <= left_q - BYTE_CNT_W'(1);
					if (left_q == BYTE_CNT_W'(1)) begin
						state_q <= last_q ? ST_LOAD_Y : ST_IDLE;
					end
				end
				ST_LOAD_Y: state_q <= ST_MUL_LL;
				ST_LOAD_X: state_q <= ST_MUL_LL;
				ST_MUL_LL: state_q <= ST_MUL_HL;
				ST_MUL_HL: state_q <= ST_MUL_LH;
				ST_MUL_LH: state_q <= ST_XSHIFT;
				ST_XSHIFT: begin
					if (!ksel_q) begin
						ksel_q <= 1'b1;
						state_q <= ST_MUL_LL;
					end else if (!second_q) begin
						ksel_q <= 1'b0;
						second_q <= 1'b1;
						state_q <= ST_LOAD_X;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/four_lane_crc32c_hash_top.sv =====
// Hashes fixed-length messages given as 64-bit little-endian words: each
// accepted word then runs its bytes through a byte-serial CRC32C unit, one
// byte per cycle, so a word inside a whole 32-byte block runs all 8 bytes, a
// trailing word only its valid bytes, and a word past the configured length
// none. The last word of a message then runs the two 64-bit finalizers, whose
// multiplications share one 32x32 multiplier, each product built from its
// low-low, high-low and low-high partial products. The hash waits in an
// output register, so the next message can start while it is still held.
`include "four_lane_crc32c_hash_top_defines.svh"

module four_lane_crc32c_hash_top
	import flch_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             word_valid,
	output logic             word_ready,
	input  logic [63:0]      data_word,
	input  logic [63:0]      seed,
	output logic             hash_valid,
	input  logic             hash_ready,
	output logic [63:0]      hash,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	flch_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.cfg_ready  (cfg_ready),
		.status     (status),
		.cmd        (cmd)
	);

	flch_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_word  (data_word),
		.seed       (seed),
		.status     (status),
		.hash       (hash),
		.hash_valid (hash_valid),
		.hash_ready (hash_ready)
	);

	`FLCH_ASSERT_NEXT(a_push_shows_hash, clk, arst_n, cmd.push, hash_valid)
	`FLCH_ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.push, !(hash_valid && !hash_ready))
	`FLCH_ASSERT_IMPL(a_crc_blocks_input, clk, arst_n, cmd.crc_step, !word_ready)
	`FLCH_ASSERT_IMPL(a_fmix_blocks_input, clk, arst_n, cmd.fm_op != FM_NONE, !word_ready)

endmodule
